FILE: hdl/cal_pkg.sv
// Shared types and constants for the cursor array list.
// Holds request and status codes, the sequencer states and interface widths.
package cal_pkg;

	localparam int DEPTH_DEF      = 128;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_W   = 4;
	localparam int VAL_W   = 32;
	localparam int POS_W   = 8;
	localparam int CNT_W   = 8;
	localparam int STAT_W  = 3;
	localparam int CAP_W   = 8;
	localparam int IN_W    = 40;
	localparam int OUT_W   = 48;

	localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

	typedef enum logic [REQ_W-1:0] {
		REQ_READ   = 4'd0,
		REQ_ZERO   = 4'd1,
		REQ_INSERT = 4'd2,
		REQ_APPEND = 4'd3,
		REQ_REMOVE = 4'd4,
		REQ_START  = 4'd5,
		REQ_END    = 4'd6,
		REQ_PREV   = 4'd7,
		REQ_NEXT   = 4'd8,
		REQ_SET    = 4'd9
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_NOELEM = 3'd3,
		ST_BOUND  = 3'd4,
		ST_REJECT = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,
		S_DRAIN,
		S_LAST,
		S_DONE
	} state_t;

endpackage

FILE: hdl/cal_ram.sv
// Element store of the cursor array list: one write port, one read port,
// read data registered. No dependencies.
module cal_ram #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [DATA_WIDTH-1:0]    wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [DATA_WIDTH-1:0]    rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

FILE: hdl/cursor_array_list.sv
// Top level of the cursor array list: request sequencer, count, cursor and
// result register around the element store. Uses cal_pkg and cal_ram.
//
// One request is taken at a time; s_axis_tready is high while the sequencer
// is idle, also while the previous result still waits on the master side.
// A read, an insert into a list that is not full and a remove, each with the
// cursor inside the list, pass through the shift and drain states (an insert
// also the last state) before done; every other request goes straight to done. Insert and remove move
// one entry per cycle through the single read and single write port of the
// store, so their time grows with the number of entries behind the cursor.
// A capacity write is taken in any cycle.
module cursor_array_list #(
	parameter int DEPTH      = cal_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = cal_pkg::DATA_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [cal_pkg::CAP_W-1:0]  cfg_data,     // capacity
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [cal_pkg::IN_W-1:0]   s_axis_tdata,  // item_value, target_position
	input  logic [cal_pkg::REQ_W-1:0]  s_axis_tuser,  // req_type
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [cal_pkg::OUT_W-1:0]  m_axis_tdata,  // item_out, element_count, cursor_position
	output logic [cal_pkg::STAT_W-1:0] m_axis_tuser   // status
);

	import cal_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = (CW > CAP_W) ? CW : CAP_W;

	state_t state_q, state_d;

	logic [CW-1:0]         count_q, cursor_q, cnt_m1;
	logic [CAP_W-1:0]      capacity_q;
	logic [REQ_W-1:0]      req_q, in_req;
	logic [DATA_WIDTH-1:0] val_q, in_val, data_q;
	logic [POS_W-1:0]      in_pos;
	logic [AW-1:0]         ptr_q, end_q, cur_a, rd_addr_s1;
	logic                  rd_vld_s1;
	status_t               status_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic [STAT_W-1:0]     out_user_q;

	logic                  in_fire, out_free, full, at_end, pos_ok, shift_wr, capture;
	logic [LW-1:0]         cnt_l, cap_l, pos_l;

	logic                  mem_we;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

	cal_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

	assign in_req = s_axis_tuser;
	assign in_val = DATA_WIDTH'(s_axis_tdata[VAL_W-1:0]);
	assign in_pos = s_axis_tdata[VAL_W+POS_W-1:VAL_W];

	assign cnt_l  = LW'(count_q);
	assign cap_l  = LW'(capacity_q);
	assign pos_l  = LW'(in_pos);
	assign cnt_m1 = count_q - 1'b1;
	assign cur_a  = cursor_q[AW-1:0];
	assign full   = (cnt_l >= cap_l) || (count_q == CW'(DEPTH));
	assign at_end = (cursor_q >= count_q);
	assign pos_ok = (pos_l != '0) && (pos_l < cnt_l);

	assign shift_wr = rd_vld_s1 && ((req_q == REQ_INSERT) ||
		((req_q == REQ_REMOVE) && (rd_addr_s1 != cur_a)));
	assign capture  = rd_vld_s1 && (req_q != REQ_INSERT) && (rd_addr_s1 == cur_a);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (in_req)
						REQ_READ:   state_d = at_end ? S_DONE : S_SHIFT;
						REQ_INSERT: state_d = (!full && !at_end) ? S_SHIFT : S_DONE;
						REQ_REMOVE: state_d = (count_q != '0 && !at_end) ? S_SHIFT : S_DONE;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_SHIFT: state_d = (ptr_q == end_q) ? S_DRAIN : S_SHIFT;
			S_DRAIN: state_d = (req_q == REQ_INSERT) ? S_LAST : S_DONE;
			S_LAST:  state_d = S_DONE;
			S_DONE:  state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cur_a;
		mem_wdata = mem_rdata;
		mem_raddr = ptr_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					unique case (in_req)
						REQ_ZERO: begin
							mem_we    = !at_end;
							mem_wdata = '0;
						end
						REQ_INSERT: begin
							mem_we    = !full && at_end;
							mem_wdata = in_val;
						end
						REQ_APPEND: begin
							mem_we    = !full;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = in_val;
						end
						default: mem_we = 1'b0;
					endcase
				end
			end
			S_SHIFT, S_DRAIN: begin
				mem_we    = shift_wr;
				mem_waddr = (req_q == REQ_INSERT) ? rd_addr_s1 + 1'b1 : rd_addr_s1 - 1'b1;
			end
			S_LAST: begin
				mem_we    = 1'b1;
				mem_wdata = val_q;
			end
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			cursor_q    <= '0;
			capacity_q  <= CAP_RESET;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_SHIFT);
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == S_LAST) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_DRAIN && req_q == REQ_REMOVE) begin
				count_q <= cnt_m1;
			end
			if (in_fire) begin
				unique case (in_req)
					REQ_INSERT: if (!full && at_end) count_q <= count_q + 1'b1;
					REQ_APPEND: if (!full) count_q <= count_q + 1'b1;
					REQ_START:  cursor_q <= '0;
					REQ_END:    cursor_q <= count_q;
					REQ_PREV:   if (cursor_q != '0) cursor_q <= cursor_q - 1'b1;
					REQ_NEXT:   if (!at_end) cursor_q <= cursor_q + 1'b1;
					REQ_SET:    if (pos_ok) cursor_q <= CW'(in_pos);
					default:    cursor_q <= cursor_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_addr_s1 <= ptr_q;
		if (state_q == S_SHIFT) begin
			ptr_q <= (req_q == REQ_INSERT) ? ptr_q - 1'b1 : ptr_q + 1'b1;
		end
		if ((state_q == S_SHIFT || state_q == S_DRAIN) && capture) begin
			data_q <= mem_rdata;
		end
		if (in_fire) begin
			req_q    <= in_req;
			val_q    <= in_val;
			data_q   <= '0;
			status_q <= ST_OK;
			ptr_q    <= cur_a;
			end_q    <= cur_a;
			unique case (in_req)
				REQ_READ, REQ_ZERO: if (at_end) status_q <= ST_NOELEM;
				REQ_INSERT: begin
					ptr_q <= cnt_m1[AW-1:0];
					if (full) status_q <= ST_FULL;
				end
				REQ_APPEND: if (full) status_q <= ST_FULL;
				REQ_REMOVE: begin
					end_q <= cnt_m1[AW-1:0];
					if (count_q == '0) begin
						status_q <= ST_EMPTY;
					end else if (at_end) begin
						status_q <= ST_NOELEM;
					end
				end
				REQ_PREV:   if (cursor_q == '0) status_q <= ST_BOUND;
				REQ_NEXT:   if (at_end) status_q <= ST_BOUND;
				REQ_SET:    if (!pos_ok) status_q <= ST_REJECT;
				default:    status_q <= ST_OK;
			endcase
		end
		if (state_q == S_DONE && out_free) begin
			out_data_q <= {CNT_W'(cursor_q), CNT_W'(count_q), VAL_W'(data_q)};
			out_user_q <= status_q;
		end
	end

endmodule

FILE: hdl/cal_chk.sv
// Port-level checks on the result stream of the cursor array list.
// Uses cal_pkg; bound to cursor_array_list below.
module cal_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_axis_tvalid,
	input logic                       m_axis_tready,
	input logic [cal_pkg::OUT_W-1:0]  m_axis_tdata,
	input logic [cal_pkg::STAT_W-1:0] m_axis_tuser
);

	import cal_pkg::*;

	logic [CNT_W-1:0] cnt, cur;

	assign cnt = m_axis_tdata[VAL_W+CNT_W-1:VAL_W];
	assign cur = m_axis_tdata[VAL_W+2*CNT_W-1:VAL_W+CNT_W];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_EMPTY |-> cnt == '0)
		else $error("empty status with elements present");

	a_noelem: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_NOELEM |-> cur == cnt)
		else $error("no-element status with cursor inside list");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_BOUND |-> cur == '0 || cur == cnt)
		else $error("boundary status with cursor away from either end");

endmodule

bind cursor_array_list cal_chk u_cal_chk (.*);
